[hw/rtl/psss_pkg.sv]
// Shared types, widths and constants of the Phong specular shade pipeline.
package psss_pkg;

	localparam int VEC_W = 33;
	localparam int MAG_W = 20;
	localparam int SQ_W = 42;
	localparam int LEN_W = 21;
	localparam int NUM_W = 36;
	localparam int QUO_W = 16;
	localparam int SQRT_STEPS = LEN_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int NORM_LAT = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;
	localparam int POW_STEPS = 29;
	localparam int GLOSSY_STEPS = 4;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [14:0] REFL_Q16 = 15'd19661;

	localparam logic [2:0] CFG_CAM_X = 3'd0;
	localparam logic [2:0] CFG_CAM_Y = 3'd1;
	localparam logic [2:0] CFG_CAM_Z = 3'd2;
	localparam logic [2:0] CFG_INTENSITY = 3'd3;
	localparam logic [2:0] CFG_RED = 3'd4;
	localparam logic [2:0] CFG_GREEN = 3'd5;
	localparam logic [2:0] CFG_BLUE = 3'd6;

	typedef logic signed [VEC_W-1:0] vec_comp_t;
	typedef logic signed [QUO_W:0] unit_t;
	typedef logic [15:0] chan_t;
	typedef logic [31:0] ic_t;

	typedef struct packed {
		logic valid;
		logic glossy;
	} beat_ctl_t;

endpackage

[hw/rtl/psss_vec_norm.sv]
// Pipelined vector normalizer: block shift, square root and rounding dividers.
module psss_vec_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  psss_pkg::vec_comp_t vec [3],
	output logic                out_v,
	output psss_pkg::unit_t     unit [3]
);
	import psss_pkg::*;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [VEC_W-1:0] mag_s1 [3];
	logic [VEC_W-1:0] mag_s2 [3];
	logic [VEC_W-1:0] mag_s3 [3];
	logic [VEC_W-1:0] mx_s2;
	logic [5:0]       pos_s3;
	logic             zero_s3, zero_s4, zero_s5;
	logic [MAG_W-1:0] sh_s4 [3];
	logic [MAG_W-1:0] sh_s5 [3];
	logic [2*MAG_W-1:0] sq_s5 [3];

	logic             v_sq_q    [SQRT_STEPS+1];
	logic [SQ_W-1:0]  rem_q     [SQRT_STEPS+1];
	logic [LEN_W-1:0] res_q     [SQRT_STEPS+1];
	logic [2:0]       neg_sq_q  [SQRT_STEPS+1];
	logic             zero_q    [SQRT_STEPS+1];
	logic [MAG_W-1:0] sh_q      [SQRT_STEPS+1][3];

	logic             dv_q      [DIV_STEPS+1];
	logic [NUM_W-1:0] drem_q    [DIV_STEPS+1][3];
	logic [QUO_W-1:0] quo_q     [DIV_STEPS+1][3];
	logic [LEN_W-1:0] dlen_q    [DIV_STEPS+1];
	logic [2:0]       dneg_q    [DIV_STEPS+1];
	logic             dzero_q   [DIV_STEPS+1];

	logic [VEC_W-1:0] mx01;
	logic [5:0]       pos_c;

	always_comb begin
		mx01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		pos_c = '0;
		for (int i = 0; i < VEC_W; i++) begin
			if (mx_s2[i]) pos_c = 6'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_sq_q[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sq_q[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][VEC_W-1];
				mag_s1[i] <= vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
				mag_s2[i] <= mag_s1[i];
				mag_s3[i] <= mag_s2[i];
				if (pos_s3 > 6'd19) begin
					sh_s4[i] <= MAG_W'(mag_s3[i] >> (pos_s3 - 6'd19));
				end else begin
					sh_s4[i] <= MAG_W'(mag_s3[i] << (6'd19 - pos_s3));
				end
				sh_s5[i] <= sh_s4[i];
				sq_s5[i] <= (2*MAG_W)'(sh_s4[i]) * (2*MAG_W)'(sh_s4[i]);
				sh_q[0][i] <= sh_s5[i];
			end
			mx_s2 <= (mx01 > mag_s1[2]) ? mx01 : mag_s1[2];
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			neg_s4 <= neg_s3;
			neg_s5 <= neg_s4;
			neg_sq_q[0] <= neg_s5;
			pos_s3 <= pos_c;
			zero_s3 <= (mx_s2 == '0);
			zero_s4 <= zero_s3;
			zero_s5 <= zero_s4;
			zero_q[0] <= zero_s5;
			rem_q[0] <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2]);
			res_q[0] <= '0;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam int B = SQRT_STEPS - 1 - k;
		logic [SQ_W+1:0] trial;
		logic            take;

		always_comb begin
			trial = ((SQ_W+2)'(res_q[k]) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
			take = ((SQ_W+2)'(rem_q[k]) >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq_q[k+1] <= 1'b0;
			end else if (en) begin
				v_sq_q[k+1] <= v_sq_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= take ? SQ_W'((SQ_W+2)'(rem_q[k]) - trial) : rem_q[k];
				res_q[k+1] <= take ? (res_q[k] | (LEN_W'(1) << B)) : res_q[k];
				neg_sq_q[k+1] <= neg_sq_q[k];
				zero_q[k+1] <= zero_q[k];
				sh_q[k+1] <= sh_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q[0] <= 1'b0;
		end else if (en) begin
			dv_q[0] <= v_sq_q[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem_q[0][i] <= NUM_W'({sh_q[SQRT_STEPS][i], 15'b0})
					+ NUM_W'(res_q[SQRT_STEPS] >> 1);
				quo_q[0][i] <= '0;
			end
			dlen_q[0] <= res_q[SQRT_STEPS];
			dneg_q[0] <= neg_sq_q[SQRT_STEPS];
			dzero_q[0] <= zero_q[SQRT_STEPS];
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int B = DIV_STEPS - 1 - k;
		logic [NUM_W:0] dvs;
		logic [2:0]     take;

		always_comb begin
			dvs = (NUM_W+1)'(dlen_q[k]) << B;
			for (int i = 0; i < 3; i++) begin
				take[i] = ((NUM_W+1)'(drem_q[k][i]) >= dvs);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_q[k+1] <= 1'b0;
			end else if (en) begin
				dv_q[k+1] <= dv_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					drem_q[k+1][i] <= take[i] ?
						NUM_W'((NUM_W+1)'(drem_q[k][i]) - dvs) : drem_q[k][i];
					quo_q[k+1][i] <= take[i] ?
						(quo_q[k][i] | (QUO_W'(1) << B)) : quo_q[k][i];
				end
				dlen_q[k+1] <= dlen_q[k];
				dneg_q[k+1] <= dneg_q[k];
				dzero_q[k+1] <= dzero_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= dv_q[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dzero_q[DIV_STEPS]) begin
					unit[i] <= '0;
				end else if (dneg_q[DIV_STEPS][i]) begin
					unit[i] <= -$signed({1'b0, quo_q[DIV_STEPS][i]});
				end else begin
					unit[i] <= $signed({1'b0, quo_q[DIV_STEPS][i]});
				end
			end
		end
	end

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v |-> (unit[0] <= 17'sd32768 && unit[0] >= -17'sd32768
			&& unit[1] <= 17'sd32768 && unit[1] >= -17'sd32768
			&& unit[2] <= 17'sd32768 && unit[2] >= -17'sd32768))
		else $error("unit component out of range");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_q[0] && !dzero_q[0]) |-> (dlen_q[0] != '0))
		else $error("zero length for nonzero vector");

	a_sum_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(v_sq_q[0] && !zero_q[0]) |-> (rem_q[0] >= (SQ_W'(1) << 38)))
		else $error("block shift left largest component unnormalized");

endmodule

[hw/rtl/psss_power.sv]
// Pipelined power chain, squaring, reflectivity scale and per-channel color product.
module psss_power (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  psss_pkg::beat_ctl_t in_ctl,
	input  logic [30:0]         c,
	input  psss_pkg::ic_t       ic [3],
	output logic                out_v,
	output psss_pkg::chan_t     spec [3]
);
	import psss_pkg::*;

	logic        v_q  [POW_STEPS+1];
	logic        gl_q [POW_STEPS+1];
	logic [30:0] p_q  [POW_STEPS+1];
	logic [30:0] c_q  [POW_STEPS+1];

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [30:0] q_s1;
	logic [29:0] t_s2;
	logic [61:0] m_s3 [3];
	chan_t       spec_s4 [3];

	logic [61:0] pp;
	logic [45:0] tq;
	logic [62:0] rs [3];

	always_comb begin
		pp = 62'(p_q[POW_STEPS]) * 62'(p_q[POW_STEPS]) + (62'(1) << 29);
		tq = 46'(q_s1) * 46'(REFL_Q16) + (46'(1) << 15);
		for (int i = 0; i < 3; i++) begin
			rs[i] = 63'(m_s3[i]) + (63'(1) << 45);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_ctl.valid;
			v_s1 <= v_q[POW_STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gl_q[0] <= in_ctl.glossy;
			p_q[0] <= c;
			c_q[0] <= c;
			q_s1 <= 31'(pp >> 30);
			t_s2 <= 30'(tq >> 16);
			for (int i = 0; i < 3; i++) begin
				m_s3[i] <= 62'(t_s2) * 62'(ic[i]);
				spec_s4[i] <= rs[i][62] ? 16'hFFFF : rs[i][61:46];
			end
		end
	end

	for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
		localparam bit ALWAYS = (k < GLOSSY_STEPS);
		logic [61:0] prod;

		always_comb begin
			prod = 62'(p_q[k]) * 62'(c_q[k]) + (62'(1) << 29);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_q[k+1] <= (ALWAYS || !gl_q[k]) ? 31'(prod >> 30) : p_q[k];
				c_q[k+1] <= c_q[k];
				gl_q[k+1] <= gl_q[k];
			end
		end
	end

	assign out_v = v_s4;
	assign spec = spec_s4;

endmodule

[hw/rtl/phong_specular_shade_unit.sv]
// Top level of the Phong specular shade unit: config, front end, dot product, output skid.
// Takes one surface hit per clock while in_stall is low and returns one beat of three
// specular color channels per hit, in order. The latency is set by the 21-step square
// root and 16-step rounding dividers in each vector normalizer and by the 29-stage
// power chain; every stage is a register, so a new hit may enter every cycle while
// in_stall is low. Output beats sit in an output register with a one-beat skid, so
// in_stall rises only once both are full. Configuration registers (0..2 camera x/y/z,
// 3 intensity, 4..6 red/green/blue) are written through the cfg port, always ready;
// index 7 is ignored. Write them only while the unit is empty.
module phong_specular_shade_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] hit_x,
	input  logic signed [31:0] hit_y,
	input  logic signed [31:0] hit_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic signed [31:0] to_light_x,
	input  logic signed [31:0] to_light_y,
	input  logic signed [31:0] to_light_z,
	input  logic        glossy_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] spec_red,
	output logic [15:0] spec_green,
	output logic [15:0] spec_blue,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import psss_pkg::*;

	localparam logic signed [49:0] D_MAX = 50'sd1073741824;
	localparam logic signed [49:0] D_MIN = -50'sd1073741824;
	localparam logic signed [35:0] C_MAX = 36'sd1073741824;

	logic signed [31:0] cam_q [3];
	logic [15:0] inten_q;
	logic [15:0] col_q [3];
	ic_t         ic_q [3];

	logic en;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic               gl_s1, gl_s2, gl_s3, gl_s4, gl_s5, gl_s6;
	logic signed [47:0] prod_s1 [3];
	vec_comp_t          vw_s1 [3];
	vec_comp_t          vw_s2 [3];
	vec_comp_t          vw_s3 [3];
	vec_comp_t          vw_s4 [3];
	logic signed [15:0] nrm_s1 [3];
	logic signed [15:0] nrm_s2 [3];
	logic signed [31:0] lig_s1 [3];
	logic signed [31:0] lig_s2 [3];
	logic signed [31:0] lig_s3 [3];
	logic signed [31:0] d_s2;
	logic signed [47:0] m_s3 [3];
	vec_comp_t          r_s4 [3];
	logic signed [33:0] pr_s5 [3];
	logic [30:0]        c_s6;
	logic               gl_dly_q [NORM_LAT];

	logic signed [15:0] nrm_in [3];
	logic signed [31:0] lig_in [3];
	logic signed [31:0] hit_in [3];
	logic signed [49:0] dsum;
	logic signed [49:0] rsh [3];
	logic signed [35:0] csum;

	logic      ru_v, vu_v;
	unit_t     ru [3];
	unit_t     vu [3];
	beat_ctl_t ctl_w;
	logic      pw_v;
	chan_t     pw_spec [3];

	logic  out_v_q, skid_v_q;
	chan_t out_d_q [3];
	chan_t skid_d_q [3];

	assign cfg_ready = 1'b1;
	assign en = !skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			inten_q <= '0;
			col_q[0] <= '0;
			col_q[1] <= '0;
			col_q[2] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CAM_X: cam_q[0] <= cfg_data;
				CFG_CAM_Y: cam_q[1] <= cfg_data;
				CFG_CAM_Z: cam_q[2] <= cfg_data;
				CFG_INTENSITY: inten_q <= cfg_data[15:0];
				CFG_RED: col_q[0] <= cfg_data[15:0];
				CFG_GREEN: col_q[1] <= cfg_data[15:0];
				CFG_BLUE: col_q[2] <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ic_q[i] <= 32'(inten_q) * 32'(col_q[i]);
		end
	end

	always_comb begin
		nrm_in[0] = norm_x;
		nrm_in[1] = norm_y;
		nrm_in[2] = norm_z;
		lig_in[0] = to_light_x;
		lig_in[1] = to_light_y;
		lig_in[2] = to_light_z;
		hit_in[0] = hit_x;
		hit_in[1] = hit_y;
		hit_in[2] = hit_z;
		dsum = 50'(prod_s1[0]) + 50'(prod_s1[1]) + 50'(prod_s1[2]);
		for (int i = 0; i < 3; i++) begin
			rsh[i] = ((50'(m_s3[i]) <<< 1) + 50'sd134217728) >>> 28;
		end
		csum = 36'(pr_s5[0]) + 36'(pr_s5[1]) + 36'(pr_s5[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= ru_v;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= 48'(lig_in[i]) * 48'(nrm_in[i]);
				vw_s1[i] <= VEC_W'(cam_q[i]) - VEC_W'(hit_in[i]);
				nrm_s1[i] <= nrm_in[i];
				lig_s1[i] <= lig_in[i];
				vw_s2[i] <= vw_s1[i];
				nrm_s2[i] <= nrm_s1[i];
				lig_s2[i] <= lig_s1[i];
				m_s3[i] <= 48'(d_s2) * 48'(nrm_s2[i]);
				vw_s3[i] <= vw_s2[i];
				lig_s3[i] <= lig_s2[i];
				r_s4[i] <= VEC_W'(rsh[i]) - VEC_W'(lig_s3[i]);
				vw_s4[i] <= vw_s3[i];
				pr_s5[i] <= 34'(ru[i]) * 34'(vu[i]);
			end
			gl_s1 <= glossy_select;
			gl_s2 <= gl_s1;
			gl_s3 <= gl_s2;
			gl_s4 <= gl_s3;
			if (dsum > D_MAX) begin
				d_s2 <= 32'(D_MAX);
			end else if (dsum < D_MIN) begin
				d_s2 <= 32'(D_MIN);
			end else begin
				d_s2 <= 32'(dsum);
			end
			gl_dly_q[0] <= gl_s4;
			for (int k = 1; k < NORM_LAT; k++) begin
				gl_dly_q[k] <= gl_dly_q[k-1];
			end
			gl_s5 <= gl_dly_q[NORM_LAT-1];
			gl_s6 <= gl_s5;
			if (csum < 0) begin
				c_s6 <= '0;
			end else if (csum > C_MAX) begin
				c_s6 <= ONE_Q30;
			end else begin
				c_s6 <= 31'(csum);
			end
		end
	end

	psss_vec_norm u_norm_r (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s4),
		.vec    (r_s4),
		.out_v  (ru_v),
		.unit   (ru)
	);

	psss_vec_norm u_norm_v (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s4),
		.vec    (vw_s4),
		.out_v  (vu_v),
		.unit   (vu)
	);

	assign ctl_w = '{valid: v_s6, glossy: gl_s6};

	psss_power u_power (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_ctl (ctl_w),
		.c      (c_s6),
		.ic     (ic_q),
		.out_v  (pw_v),
		.spec   (pw_spec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pw_v;
			end
		end else if (pw_v && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			for (int i = 0; i < 3; i++) begin
				out_d_q[i] <= skid_v_q ? skid_d_q[i] : pw_spec[i];
			end
		end else if (!skid_v_q) begin
			skid_d_q <= pw_spec;
		end
	end

	assign out_valid = out_v_q;
	assign spec_red = out_d_q[0];
	assign spec_green = out_d_q[1];
	assign spec_blue = out_d_q[2];

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a beat with output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !out_stall) |=> !skid_v_q)
		else $error("skid beat not drained");

	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_stall && !skid_v_q && pw_v) |=> skid_v_q)
		else $error("beat lost while output stalled");

	a_norm_align: assert property (@(posedge clk) disable iff (!arst_n)
		ru_v == vu_v)
		else $error("normalizer lanes out of step");

endmodule
